/* src/cedd_pkg.sv */
// Shared constants, codes and the result record of the crate event word deframer.
package cedd_pkg;

  localparam int CRATES           = 4;
  localparam int CRATE_W          = 2;
  localparam int BUFFER_WORDS_MAX = 262144;
  localparam int SLOTS            = 23;
  localparam int POS_W            = 19;
  localparam int MASK_W           = 23;
  localparam int CNT_W            = 3;
  localparam int CFG_IDX_W        = 3;

  localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] BUF_MAX_POS = POS_W'(BUFFER_WORDS_MAX);
  localparam logic [31:0]      TRAILER_WORD = 32'hff00_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CRATE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK0       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK3       = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_HIT    = 2'd0;
  localparam logic [1:0] KIND_EVENT  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // buffer status codes
  localparam logic [2:0] ST_CONTINUE = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_SERIAL   = 3'd2;
  localparam logic [2:0] ST_LARGE    = 3'd3;
  localparam logic [2:0] ST_SHORT    = 3'd4;
  localparam logic [2:0] ST_OVERRUN  = 3'd5;
  localparam logic [2:0] ST_LIMIT    = 3'd6;

  // block phase codes
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_DATA    = 2'd1;
  localparam logic [1:0] PH_TRAILER = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  crate_id;
    logic [4:0]  module_id;
    logic [7:0]  subaddress;
    logic [15:0] hit_value;
    logic [31:0] event_id;
    logic        event_good;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // results written by one input transfer
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

/* src/cedd_in_if.sv */
// Input channel: buffer starts and stream words.
interface cedd_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  crate_sel;
  logic [18:0] buffer_words;
  logic [31:0] word;

  modport source (output valid, output func, output crate_sel, output buffer_words,
                  output word, input ready);
  modport sink (input valid, input func, input crate_sel, input buffer_words,
                input word, output ready);
endinterface

/* src/cedd_out_if.sv */
// Output channel: hits, event ends and buffer status.
interface cedd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  crate_id;
  logic [4:0]  module_id;
  logic [7:0]  subaddress;
  logic [15:0] hit_value;
  logic [31:0] event_id;
  logic        event_good;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output kind, output crate_id, output module_id,
                  output subaddress, output hit_value, output event_id,
                  output event_good, output status, output last, input ready);
  modport sink (input valid, input kind, input crate_id, input module_id,
                input subaddress, input hit_value, input event_id,
                input event_good, input status, input last, output ready);
endinterface

/* src/cedd_res_fifo.sv */
// Four-entry result queue that takes up to two results per cycle.
module cedd_res_fifo import cedd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  result_t    mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign room_o  = (cnt_q <= 3'd2);
  assign pop     = valid_o & ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.num;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    cnt_d    = cnt_q + {1'b0, push_i.num} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push_i.second;
    end
  end

endmodule

/* src/crate_event_word_deframer.sv */
// Top level: rebuilds events from per-crate block streams and decodes hits.
//
//  channel  | dir | carries                                      | transfer
//  ---------+-----+----------------------------------------------+-------------------
//  in_i     | in  | func, crate_sel, buffer_words, word          | valid & ready
//  out_o    | out | kind, crate_id, module_id, subaddress, ...   | valid & ready
//  cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i              | cfg_we_i high
//
// Each input transfer is decoded in the cycle it is taken and its zero, one or two
// results land in a four-entry result queue; a new input can be taken in the next cycle while the queue has room.
// One input per cycle is sustained while results drain; an input that yields two
// results leaves them on the output port one after the other. in_i.ready is high while the queue
// holds at most two entries, so a stalled output fills the queue and then holds input.
// Reset clears all per-crate and event state, sets the event number to 1 and leaves the queue empty.
module crate_event_word_deframer import cedd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cedd_in_if.sink              in_i,
  cedd_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  // configuration
  logic [2:0]        crate_count_q;
  logic [31:0]       event_limit_q;
  logic [MASK_W-1:0] short_mask_q [4];

  // per-crate state
  logic [POS_W-1:0] blen_q [CRATES];
  logic [POS_W-1:0] blen_d [CRATES];
  logic [POS_W-1:0] rpos_q [CRATES];
  logic [POS_W-1:0] rpos_d [CRATES];
  logic [15:0]      pser_q [CRATES];
  logic [15:0]      pser_d [CRATES];
  logic             psv_q  [CRATES];
  logic             psv_d  [CRATES];

  // event state
  logic [CRATE_W-1:0] cur_q, cur_d;
  logic [1:0]         phase_q, phase_d;
  logic [15:0]        wleft_q, wleft_d;
  logic [POS_W-1:0]   ewc_q, ewc_d;
  logic               tmiss_q, tmiss_d;
  logic [31:0]        evcnt_q, evcnt_d;
  logic               aborted_q, aborted_d;
  logic               stopped_q, stopped_d;

  logic    in_fire;
  logic    room;
  push_t   push;
  result_t out_data;

  cedd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_data)
  );

  assign in_i.ready = room;
  assign in_fire    = in_i.valid & room;

  assign out_o.kind       = out_data.kind;
  assign out_o.crate_id   = out_data.crate_id;
  assign out_o.module_id  = out_data.module_id;
  assign out_o.subaddress = out_data.subaddress;
  assign out_o.hit_value  = out_data.hit_value;
  assign out_o.event_id   = out_data.event_id;
  assign out_o.event_good = out_data.event_good;
  assign out_o.status     = out_data.status;
  assign out_o.last       = out_data.last;

  // decode and state update
  logic [2:0]        n_act;
  logic [15:0]       serial, nword;
  logic [4:0]        modn;
  logic [31:0]       mask_sel;
  logic              short_l;
  logic              block_end;
  logic              tm_new;
  logic [POS_W-1:0]  ewc_n;
  logic [POS_W-1:0]  len;
  logic              all_eq, any_eq, any_over;
  logic [2:0]        st;
  logic              good;

  always_comb begin
    blen_d    = blen_q;
    rpos_d    = rpos_q;
    pser_d    = pser_q;
    psv_d     = psv_q;
    cur_d     = cur_q;
    phase_d   = phase_q;
    wleft_d   = wleft_q;
    ewc_d     = ewc_q;
    tmiss_d   = tmiss_q;
    evcnt_d   = evcnt_q;
    aborted_d = aborted_q;
    stopped_d = stopped_q;
    push      = '0;
    block_end = 1'b0;
    tm_new    = 1'b0;
    all_eq    = 1'b1;
    any_eq    = 1'b0;
    any_over  = 1'b0;
    st        = ST_CONTINUE;
    good      = 1'b0;
    ewc_n     = ewc_q;

    if (crate_count_q == 3'd0) begin
      n_act = 3'd1;
    end else if (int'(crate_count_q) > CRATES) begin
      n_act = 3'(CRATES);
    end else begin
      n_act = crate_count_q;
    end

    serial   = in_i.word[31:16];
    nword    = in_i.word[15:0];
    modn     = in_i.word[31:27];
    mask_sel = {{(32-MASK_W){1'b0}}, short_mask_q[cur_q]};
    short_l  = (modn != 5'd0) && (int'(modn) <= SLOTS) && mask_sel[modn - 5'd1];
    len      = (in_i.buffer_words > BUF_MAX_POS) ? BUF_MAX_POS : in_i.buffer_words;

    if (in_fire && !stopped_q) begin
      if (!in_i.func) begin
        if (int'(in_i.crate_sel) < CRATES) begin
          blen_d[in_i.crate_sel] = len;
          rpos_d[in_i.crate_sel] = '0;
          psv_d[in_i.crate_sel]  = 1'b0;
          aborted_d = 1'b0;
          cur_d     = '0;
          phase_d   = PH_HEADER;
          wleft_d   = '0;
          ewc_d     = '0;
          tmiss_d   = 1'b0;
        end
      end else if (!aborted_q) begin
        if (rpos_q[cur_q] != POS_MAX) begin
          rpos_d[cur_q] = rpos_q[cur_q] + POS_W'(1);
        end
        case (phase_q)
          PH_HEADER: begin
            if (psv_q[cur_q] && (pser_q[cur_q] < serial) &&
                (pser_q[cur_q] + 16'd1 != serial)) begin
              aborted_d          = 1'b1;
              push.num           = 2'd1;
              push.first.kind    = KIND_STATUS;
              push.first.status  = ST_SERIAL;
              push.first.last    = 1'b1;
            end else begin
              pser_d[cur_q] = serial;
              psv_d[cur_q]  = 1'b1;
              if (nword == 16'd0) begin
                block_end = 1'b1;
              end else begin
                wleft_d = nword - 16'd1;
                phase_d = (nword == 16'd1) ? PH_TRAILER : PH_DATA;
              end
            end
          end
          PH_DATA: begin
            if (ewc_q <= BUF_MAX_POS) begin
              ewc_n = ewc_q + POS_W'(1);
            end
            ewc_d = ewc_n;
            push.num        = 2'd1;
            push.first.last = 1'b1;
            if (ewc_n > BUF_MAX_POS) begin
              aborted_d         = 1'b1;
              push.first.kind   = KIND_STATUS;
              push.first.status = ST_LARGE;
            end else begin
              push.first.kind      = KIND_HIT;
              push.first.crate_id  = cur_q;
              push.first.module_id = modn;
              push.first.event_id  = evcnt_q;
              if (short_l) begin
                push.first.subaddress = {3'b0, in_i.word[15:11]};
                push.first.hit_value  = {5'b0, in_i.word[10:0]};
              end else begin
                push.first.subaddress = in_i.word[23:16];
                push.first.hit_value  = in_i.word[15:0];
              end
              if (wleft_q > 16'd0) begin
                wleft_d = wleft_q - 16'd1;
              end
              if (wleft_q <= 16'd1) begin
                phase_d = PH_TRAILER;
              end
            end
          end
          default: begin
            block_end = 1'b1;
          end
        endcase

        if (block_end) begin
          tm_new  = tmiss_q | (in_i.word != TRAILER_WORD);
          phase_d = PH_HEADER;
          if ({1'b0, cur_q} + 3'd1 < n_act) begin
            cur_d   = cur_q + CRATE_W'(1);
            tmiss_d = tm_new;
          end else begin
            good    = ~tm_new;
            cur_d   = '0;
            ewc_d   = '0;
            tmiss_d = 1'b0;
            push.num              = 2'd2;
            push.first.kind       = KIND_EVENT;
            push.first.event_id   = evcnt_q;
            push.first.event_good = good;
            push.second.kind      = KIND_STATUS;
            push.second.last      = 1'b1;
            if (good && (event_limit_q != 32'd0) && (evcnt_q >= event_limit_q)) begin
              stopped_d          = 1'b1;
              push.second.status = ST_LIMIT;
            end else begin
              if (evcnt_q != '1) begin
                evcnt_d = evcnt_q + 32'd1;
              end
              // compare read positions of the active crates against their lengths
              for (int i = 0; i < CRATES; i++) begin
                if (i < int'(n_act)) begin
                  if (rpos_d[i] == blen_q[i]) begin
                    any_eq = 1'b1;
                  end else begin
                    all_eq = 1'b0;
                  end
                  if (rpos_d[i] > blen_q[i]) begin
                    any_over = 1'b1;
                  end
                end
              end
              if (all_eq) begin
                st = ST_DONE;
              end else if (any_eq) begin
                st = ST_SHORT;
              end else if (any_over) begin
                st = ST_OVERRUN;
              end else begin
                st = ST_CONTINUE;
              end
              if (st != ST_CONTINUE) begin
                aborted_d = 1'b1;
              end
              push.second.status = st;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crate_count_q <= 3'(CRATES);
      event_limit_q <= '0;
      for (int i = 0; i < 4; i++) begin
        short_mask_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CRATE_COUNT: crate_count_q <= cfg_data_i[2:0];
        CFG_EVENT_LIMIT: event_limit_q <= cfg_data_i;
        default: begin
          if (cfg_idx_i >= CFG_MASK0 && cfg_idx_i <= CFG_MASK3) begin
            short_mask_q[2'(cfg_idx_i - CFG_MASK0)] <= cfg_data_i[MASK_W-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CRATES; i++) begin
        blen_q[i] <= '0;
        rpos_q[i] <= '0;
        pser_q[i] <= '0;
        psv_q[i]  <= 1'b0;
      end
      cur_q     <= '0;
      phase_q   <= PH_HEADER;
      wleft_q   <= '0;
      ewc_q     <= '0;
      tmiss_q   <= 1'b0;
      evcnt_q   <= 32'd1;
      aborted_q <= 1'b0;
      stopped_q <= 1'b0;
    end else begin
      blen_q    <= blen_d;
      rpos_q    <= rpos_d;
      pser_q    <= pser_d;
      psv_q     <= psv_d;
      cur_q     <= cur_d;
      phase_q   <= phase_d;
      wleft_q   <= wleft_d;
      ewc_q     <= ewc_d;
      tmiss_q   <= tmiss_d;
      evcnt_q   <= evcnt_d;
      aborted_q <= aborted_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

/* verif/crate_event_word_deframer_tb.sv */
// Self-checking testbench for the crate event word deframer: directed and random block streams.
`timescale 1ns / 100ps

module crate_event_word_deframer_tb;
  import cedd_pkg::*;

  localparam int RANDOM_ITEMS   = 425;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_CAP     = 30;

  // Tracks the deframer state and holds the hits, event ends and status words it must emit.
  class deframer_scoreboard;
    logic [CNT_W-1:0]   crate_count;
    logic [31:0]        event_limit;
    logic [MASK_W-1:0]  short_mask [CRATES];
    logic [POS_W-1:0]   buf_len [CRATES];
    logic [POS_W-1:0]   rd_pos [CRATES];
    logic [15:0]        last_serial [CRATES];
    bit                 serial_seen [CRATES];
    logic [CRATE_W-1:0] cur_crate;
    logic [1:0]         phase;
    logic [15:0]        words_left;
    logic [POS_W-1:0]   event_words;
    bit                 trailer_bad;
    logic [31:0]        event_no;
    bit                 aborted;
    bit                 stopped;
    result_t            decoded_q [$];
    int                 errors;
    int                 inputs_seen;
    int                 hits;
    int                 good_events;
    int                 bad_events;
    int                 status_seen [8];

    function new();
      int c;
      crate_count = CNT_W'(CRATES);
      event_limit = '0;
      for (c = 0; c < CRATES; c++) begin
        short_mask[c]  = '0;
        buf_len[c]     = '0;
        rd_pos[c]      = '0;
        last_serial[c] = '0;
        serial_seen[c] = 1'b0;
      end
      for (c = 0; c < 8; c++) status_seen[c] = 0;
      cur_crate   = '0;
      phase       = PH_HEADER;
      words_left  = '0;
      event_words = '0;
      trailer_bad = 1'b0;
      event_no    = 32'd1;
      aborted     = 1'b0;
      stopped     = 1'b0;
      errors      = 0;
      inputs_seen = 0;
      hits        = 0;
      good_events = 0;
      bad_events  = 0;
    endfunction

    function int active_crates();
      if (crate_count < 1) return 1;
      if (crate_count > CRATES) return CRATES;
      return int'(crate_count);
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
      if (idx == CFG_CRATE_COUNT) crate_count = data[CNT_W-1:0];
      else if (idx == CFG_EVENT_LIMIT) event_limit = data;
      else if (idx >= CFG_MASK0 && idx <= CFG_MASK3)
        short_mask[int'(idx - CFG_MASK0)] = data[MASK_W-1:0];
    endfunction

    function void emit(input logic [1:0] kind, input logic [1:0] cr, input logic [4:0] mod,
                       input logic [7:0] sub, input logic [15:0] val, input logic [31:0] evid,
                       input logic good, input logic [2:0] st, input logic last);
      result_t r;
      r.kind       = kind;
      r.crate_id   = cr;
      r.module_id  = mod;
      r.subaddress = sub;
      r.hit_value  = val;
      r.event_id   = evid;
      r.event_good = good;
      r.status     = st;
      r.last       = last;
      decoded_q.push_back(r);
    endfunction

    function void abort_buffer(input logic [2:0] st);
      aborted = 1'b1;
      emit(KIND_STATUS, '0, '0, '0, '0, '0, 1'b0, st, 1'b1);
    endfunction

    // Trailer (or empty header) of the current crate's block.
    function void close_block(input logic [31:0] w);
      int n;
      int c;
      int eq;
      int over;
      bit good;
      logic [2:0] st;
      n = active_crates();
      eq = 0;
      over = 0;
      if (w != TRAILER_WORD) trailer_bad = 1'b1;
      phase = PH_HEADER;
      if (int'(cur_crate) + 1 < n) begin
        cur_crate++;
        return;
      end
      good = !trailer_bad;
      emit(KIND_EVENT, '0, '0, '0, '0, event_no, good, ST_CONTINUE, 1'b0);
      cur_crate = '0;
      event_words = '0;
      trailer_bad = 1'b0;
      if (good && event_limit != 0 && event_no >= event_limit) begin
        stopped = 1'b1;
        emit(KIND_STATUS, '0, '0, '0, '0, '0, 1'b0, ST_LIMIT, 1'b1);
        return;
      end
      if (event_no != 32'hFFFF_FFFF) event_no++;
      for (c = 0; c < n; c++) begin
        if (rd_pos[c] == buf_len[c]) eq++;
        if (rd_pos[c] > buf_len[c]) over++;
      end
      if (eq == n) st = ST_DONE;
      else if (eq >= 1) st = ST_SHORT;
      else if (over >= 1) st = ST_OVERRUN;
      else st = ST_CONTINUE;
      if (st != ST_CONTINUE) aborted = 1'b1;
      emit(KIND_STATUS, '0, '0, '0, '0, '0, 1'b0, st, 1'b1);
    endfunction

    function void note_input(input logic f, input logic [1:0] cs, input logic [18:0] bw,
                             input logic [31:0] w);
      logic [POS_W-1:0] len;
      int c;
      logic [15:0] serial;
      logic [15:0] nword;
      logic [4:0] mod;
      bit shortl;
      logic [7:0] sub;
      logic [15:0] val;
      inputs_seen++;
      if (stopped) return;
      if (f == 1'b0) begin
        if (int'(cs) >= CRATES) return;
        c = int'(cs);
        len = bw;
        if (len > BUF_MAX_POS) len = BUF_MAX_POS;
        buf_len[c] = len;
        rd_pos[c] = '0;
        serial_seen[c] = 1'b0;
        aborted = 1'b0;
        cur_crate = '0;
        phase = PH_HEADER;
        words_left = '0;
        event_words = '0;
        trailer_bad = 1'b0;
        return;
      end
      if (aborted) return;
      c = int'(cur_crate);
      if (rd_pos[c] < POS_MAX) rd_pos[c]++;
      case (phase)
        PH_HEADER: begin
          serial = w[31:16];
          nword = w[15:0];
          if (serial_seen[c] && last_serial[c] < serial &&
              ({1'b0, last_serial[c]} + 17'd1) != {1'b0, serial}) begin
            abort_buffer(ST_SERIAL);
            return;
          end
          last_serial[c] = serial;
          serial_seen[c] = 1'b1;
          if (nword == 0) begin
            close_block(w);
            return;
          end
          words_left = nword - 16'd1;
          phase = (nword == 16'd1) ? PH_TRAILER : PH_DATA;
        end
        PH_DATA: begin
          mod = w[31:27];
          shortl = 1'b0;
          if (mod >= 1 && mod <= SLOTS) shortl = short_mask[c][mod - 5'd1];
          if (event_words <= BUFFER_WORDS_MAX) event_words++;
          if (event_words > BUFFER_WORDS_MAX) begin
            abort_buffer(ST_LARGE);
            return;
          end
          if (shortl) begin
            sub = {3'b000, w[15:11]};
            val = {5'b00000, w[10:0]};
          end else begin
            sub = w[23:16];
            val = w[15:0];
          end
          emit(KIND_HIT, 2'(c), mod, sub, val, event_no, 1'b0, ST_CONTINUE, 1'b1);
          if (words_left > 0) words_left--;
          if (words_left == 0) phase = PH_TRAILER;
        end
        default: close_block(w);
      endcase
    endfunction

    task report_mismatch(input string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task match_result(input result_t got);
      result_t want;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: kind %0d status %0d",
                                  got.kind, got.status));
        return;
      end
      want = decoded_q.pop_front();
      cmp_field("kind", 32'(got.kind), 32'(want.kind));
      cmp_field("crate_id", 32'(got.crate_id), 32'(want.crate_id));
      cmp_field("module_id", 32'(got.module_id), 32'(want.module_id));
      cmp_field("subaddress", 32'(got.subaddress), 32'(want.subaddress));
      cmp_field("hit_value", 32'(got.hit_value), 32'(want.hit_value));
      cmp_field("event_id", got.event_id, want.event_id);
      cmp_field("event_good", 32'(got.event_good), 32'(want.event_good));
      cmp_field("status", 32'(got.status), 32'(want.status));
      cmp_field("last", 32'(got.last), 32'(want.last));
      if (want.kind == KIND_HIT) hits++;
      else if (want.kind == KIND_EVENT && want.event_good) good_events++;
      else if (want.kind == KIND_EVENT) bad_events++;
      else status_seen[want.status]++;
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]          cfg_data;
  bit                   in_gaps;
  bit                   out_gaps;
  int                   items_sent;
  int                   stuck_cycles;
  deframer_scoreboard   sb;

  cedd_in_if  in_if ();
  cedd_out_if out_if ();

  crate_event_word_deframer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sample both channels mid-cycle; a transfer seen here completes at the next rising edge.
  always @(negedge clk_i) begin
    result_t seen;
    if (rst_ni === 1'b1) begin
      if (in_if.valid && in_if.ready)
        sb.note_input(in_if.func, in_if.crate_sel, in_if.buffer_words, in_if.word);
      if (out_if.valid && out_if.ready) begin
        seen.kind       = out_if.kind;
        seen.crate_id   = out_if.crate_id;
        seen.module_id  = out_if.module_id;
        seen.subaddress = out_if.subaddress;
        seen.hit_value  = out_if.hit_value;
        seen.event_id   = out_if.event_id;
        seen.event_good = out_if.event_good;
        seen.status     = out_if.status;
        seen.last       = out_if.last;
        sb.match_result(seen);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stuck_cycles = 0;
      else stuck_cycles++;
    end
  end

  initial begin
    wait (stuck_cycles >= WATCHDOG_LIMIT);
    $display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("crate_event_word_deframer_tb: done, errors");
    $finish;
  end

  // Output back-pressure: random stall bursts while enabled.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_gaps && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Present one item and hold it until the transfer; returns just after the accepting edge.
  task automatic push_item(input logic f, input logic [1:0] cs, input logic [18:0] bw,
                           input logic [31:0] w);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= f;
    in_if.crate_sel    <= cs;
    in_if.buffer_words <= bw;
    in_if.word         <= w;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic start_buffer(input logic [1:0] cs, input logic [18:0] len);
    push_item(1'b0, cs, len, $urandom);
  endtask

  task automatic push_word(input logic [31:0] w);
    push_item(1'b1, 2'($urandom), 19'($urandom), w);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 39) == 0)
      push_item(1'($urandom), 2'($urandom), 19'($urandom), $urandom);
  endtask

  // Drop valid, let every pending result drain, then allow for inputs still in flight.
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    while (sb.decoded_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [31:0] cc, input logic [31:0] lim,
                               input logic [31:0] m0, input logic [31:0] m1,
                               input logic [31:0] m2, input logic [31:0] m3);
    logic [31:0] vals [6];
    logic [CFG_IDX_W-1:0] idx [6];
    int i;
    vals[0] = cc;
    vals[1] = lim;
    vals[2] = m0;
    vals[3] = m1;
    vals[4] = m2;
    vals[5] = m3;
    idx[0] = CFG_CRATE_COUNT;
    idx[1] = CFG_EVENT_LIMIT;
    for (i = 0; i < CRATES; i++) idx[2 + i] = CFG_MASK0 + CFG_IDX_W'(i);
    for (i = 0; i < 6; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_block_words();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 0;
    if (r == 2) return $urandom_range(7, 40);
    return $urandom_range(1, 6);
  endfunction

  // One buffer set: starts for the active crates (and at random for others), then one to four events of crate blocks.
  task automatic run_buffer();
    int n;
    int nev;
    int rot;
    int c;
    int e;
    int k;
    int len;
    int nw [4][4];
    int total [4];
    logic [15:0] serial [4];
    logic [31:0] w;
    n = sb.active_crates();
    nev = $urandom_range(1, 4);
    for (c = 0; c < CRATES; c++) begin
      total[c] = 0;
      serial[c] = 16'($urandom);
    end
    for (e = 0; e < nev; e++)
      for (c = 0; c < n; c++) begin
        nw[e][c] = pick_block_words();
        total[c] += (nw[e][c] == 0) ? 1 : nw[e][c] + 1;
      end
    rot = $urandom_range(0, 3);
    for (k = 0; k < CRATES; k++) begin
      c = (rot + k) % CRATES;
      case ($urandom_range(0, 15))
        0, 1: len = total[c] + $urandom_range(1, 5);
        2, 3: len = (total[c] > 1) ? total[c] - $urandom_range(1, total[c] - 1) : 0;
        4: len = $urandom_range(0, 19'h7FFFF);
        default: len = total[c];
      endcase
      if (c < n || $urandom_range(0, 3) == 0) start_buffer(2'(c), 19'(len));
    end
    for (e = 0; e < nev; e++)
      for (c = 0; c < n; c++) begin
        maybe_noise();
        if (nw[e][c] == 0 && e == 0 && $urandom_range(0, 1) == 1) begin
          // empty block whose header doubles as a valid trailer
          w = TRAILER_WORD;
          serial[c] = w[31:16];
        end else begin
          if (e > 0) begin
            case ($urandom_range(0, 19))
              0: ;
              1: serial[c] = serial[c] - 16'($urandom_range(1, 3));
              2: serial[c] = serial[c] + 16'($urandom_range(2, 50));
              default: serial[c] = serial[c] + 16'd1;
            endcase
          end
          w = {serial[c], 16'(nw[e][c])};
        end
        push_word(w);
        for (k = 1; k < nw[e][c]; k++) begin
          maybe_noise();
          push_word($urandom);
        end
        if (nw[e][c] != 0)
          push_word(($urandom_range(0, 11) == 0) ? $urandom : TRAILER_WORD);
      end
  endtask

  initial begin
    int phase_no;
    int tries;
    sb = new();
    stuck_cycles = 0;
    items_sent = 0;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_CRATE_COUNT;
    cfg_data           <= '0;
    in_if.valid        <= 1'b0;
    in_if.func         <= 1'b0;
    in_if.crate_sel    <= '0;
    in_if.buffer_words <= '0;
    in_if.word         <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: two crates, crate 0 all short, crate 1 slot 1 short.
    load_settings(32'd2, 32'd0, 32'h007F_FFFF, 32'h0000_0001, $urandom, $urandom);
    // good event, short and out-of-range module, empty crate 1 block, buffer done
    start_buffer(2'd0, 19'd4);
    start_buffer(2'd1, 19'd1);
    push_word({16'h0005, 16'd3});
    push_word(32'h0FFF_FFFF);
    push_word(32'hFFFF_FFFF);
    push_word(TRAILER_WORD);
    push_word(TRAILER_WORD);
    push_word(32'hFFFF_FFFF);
    // clamped length, bad trailer, module 1 short on crate 1, overrun
    start_buffer(2'd0, 19'h7FFFF);
    start_buffer(2'd1, 19'd0);
    push_word({16'hFFFF, 16'd1});
    push_word(32'h0000_0000);
    push_word({16'h0000, 16'd2});
    push_word(32'h0801_2345);
    push_word(TRAILER_WORD);
    // empty bad block, continue, then a serial jump
    start_buffer(2'd0, 19'd5);
    start_buffer(2'd1, 19'd6);
    push_word({16'h0010, 16'd0});
    push_word({16'h0001, 16'd1});
    push_word(TRAILER_WORD);
    push_word({16'h0011, 16'd0});
    push_word({16'h0005, 16'd1});
    push_word($urandom);

    phase_no = 0;
    while (items_sent < 25 + RANDOM_ITEMS) begin
      wait_quiet();
      in_gaps = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      case (phase_no % 8)
        0: load_settings(32'd1, 32'd0, pick_mask(), pick_mask(), pick_mask(), pick_mask());
        1: load_settings(32'd4, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
        2: load_settings(32'd3, $urandom | 32'h8000_0000, pick_mask(), pick_mask(),
                         pick_mask(), pick_mask());
        3: load_settings(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF);
        4: load_settings(32'd2, 32'hFFFF_FFFF, pick_mask(), pick_mask(), pick_mask(),
                         pick_mask());
        5: load_settings(32'd7, 32'd0, pick_mask(), pick_mask(), pick_mask(), pick_mask());
        6: load_settings(32'd6, $urandom | 32'h8000_0000, pick_mask(), pick_mask(),
                         pick_mask(), pick_mask());
        default: load_settings(32'd5, 32'd0, pick_mask(), pick_mask(), pick_mask(),
                               pick_mask());
      endcase
      repeat ($urandom_range(2, 3)) run_buffer();
      phase_no++;
    end

    // Closing part without idling: reach the event limit, then show everything is ignored.
    wait_quiet();
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    load_settings($urandom_range(1, 4), sb.event_no + 32'd2, pick_mask(), pick_mask(),
                  pick_mask(), pick_mask());
    tries = 0;
    while (!sb.stopped && tries < 20) begin
      run_buffer();
      tries++;
    end
    repeat (8) push_item(1'($urandom), 2'($urandom), 19'($urandom), $urandom);
    in_if.valid <= 1'b0;

    while (sb.decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("summary: %0d transfers in, %0d hits, %0d good / %0d bad event ends, stopped=%0d",
             sb.inputs_seen, sb.hits, sb.good_events, sb.bad_events, sb.stopped);
    $display("summary: status continue %0d done %0d serial %0d short %0d overrun %0d limit %0d",
             sb.status_seen[ST_CONTINUE], sb.status_seen[ST_DONE], sb.status_seen[ST_SERIAL],
             sb.status_seen[ST_SHORT], sb.status_seen[ST_OVERRUN], sb.status_seen[ST_LIMIT]);
    if (sb.errors == 0)
      $display("crate_event_word_deframer_tb: done, clean");
    else
      $display("crate_event_word_deframer_tb: done, errors");
    $finish;
  end

endmodule
